>>> hdl/kabf_pkg.sv
// Shared types, constants and saturation helpers for the angle/bias Kalman filter.
// Used by every module of the filter; no dependencies.
package kabf_pkg;

  localparam int FRAC_BITS = 24;
  localparam int OPW       = 33;              // multiplier operand width
  localparam int PRODW     = 2 * OPW;         // exact product width
  localparam int RSW       = PRODW - FRAC_BITS; // rounded-shift result width
  localparam int DIVW      = 57;              // dividend / quotient width
  localparam int DSRW      = 33;              // divisor width
  localparam int CFG_AW    = 2;

  localparam logic [CFG_AW-1:0] REG_ANGLE_Q = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BIAS_Q  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MEAS_R  = 2'd2;

  localparam logic [31:0] RST_ANGLE_Q = 32'd16777;
  localparam logic [31:0] RST_BIAS_Q  = 32'd50332;
  localparam logic [31:0] RST_MEAS_R  = 32'd503316;

  typedef logic signed [31:0]  word_t;
  typedef logic signed [47:0]  wide_t;
  typedef logic signed [RSW-1:0] rs_t;

  typedef struct packed {
    logic                  en;
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [DIVW-1:0] dividend;
    logic [DSRW-1:0] divisor;
  } div_req_t;

  function automatic word_t sat32(input wide_t v);
    if (v > 48'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -48'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  function automatic wide_t ext_w(input word_t w);
    ext_w = {{16{w[31]}}, w};
  endfunction

  function automatic wide_t ext_rs(input rs_t r);
    ext_rs = {{(48-RSW){r[RSW-1]}}, r};
  endfunction

  function automatic wide_t ext_u(input logic [31:0] u);
    ext_u = {16'd0, u};
  endfunction

  function automatic word_t gain_sat(input logic [DIVW-1:0] q, input logic neg);
    if (!neg) begin
      if (q > {{(DIVW-32){1'b0}}, 32'h7fffffff}) gain_sat = 32'sh7fffffff;
      else                                      gain_sat = q[31:0];
    end else begin
      if (q >= {{(DIVW-32){1'b0}}, 32'h80000000}) gain_sat = 32'sh80000000;
      else                                       gain_sat = -q[31:0];
    end
  endfunction

endpackage

>>> hdl/kalman_angle_bias_filter_core.sv
// Two-state Kalman filter (angle, gyro bias) with a 2x2 covariance, fixed point.
// One transaction on in_ carries angle, rate and time step; one transaction on out_
// returns angle, bias and unbiased rate. Input is accepted only in the idle state, so a
// new item waits until the last one is done. A nonzero time step runs the predict states
// P1 to P6, two gain divisions on one restoring divider (57 quotient bits), the
// correction states C1 to C7 and the finish state, with 10 passes through one shared
// 33x33 multiplier. When the innovation variance is not positive the divisions are
// skipped; a zero time step goes straight from idle to the finish state. A finished
// result waits in the output register while the next item is accepted; the core holds
// in its finish state only while an earlier result has not been taken.
// Depends on kabf_pkg, kabf_mul and kabf_div.
module kalman_angle_bias_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // measured_angle, gyro_rate, time_step
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // angle_estimate, bias_estimate, unbiased_rate
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_P1   = 5'd1;
  localparam logic [4:0] ST_P2   = 5'd2;
  localparam logic [4:0] ST_P3   = 5'd3;
  localparam logic [4:0] ST_P4   = 5'd4;
  localparam logic [4:0] ST_P5   = 5'd5;
  localparam logic [4:0] ST_P6   = 5'd6;
  localparam logic [4:0] ST_D0   = 5'd7;
  localparam logic [4:0] ST_D1   = 5'd8;
  localparam logic [4:0] ST_D2   = 5'd9;
  localparam logic [4:0] ST_C1   = 5'd10;
  localparam logic [4:0] ST_C2   = 5'd11;
  localparam logic [4:0] ST_C3   = 5'd12;
  localparam logic [4:0] ST_C4   = 5'd13;
  localparam logic [4:0] ST_C5   = 5'd14;
  localparam logic [4:0] ST_C6   = 5'd15;
  localparam logic [4:0] ST_C7   = 5'd16;
  localparam logic [4:0] ST_FIN  = 5'd17;

  logic [4:0]           state_r, state_nxt;
  logic [31:0]          q_angle_r, q_bias_r, r_meas_r;
  kabf_pkg::word_t      angle_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  kabf_pkg::word_t      meas_r, rate_r, a_r, inner_r, y_r, k0_r, k1_r;
  kabf_pkg::rs_t        dtp11_r;
  logic [31:0]          dt_r;
  logic                 out_valid_r;
  logic [95:0]          out_data_r;
  kabf_pkg::mul_req_t   mreq;
  kabf_pkg::rs_t        rs;
  kabf_pkg::div_req_t   dreq;
  logic                 div_done;
  logic [kabf_pkg::DIVW-1:0] quo;
  logic signed [33:0]   s_val;
  logic                 s_pos;
  logic                 in_acc;
  logic                 fin_go;
  kabf_pkg::word_t      in_meas, in_gyro;
  logic [31:0]          in_dt;
  kabf_pkg::word_t      div_p;
  logic [31:0]          div_mag;
  logic signed [kabf_pkg::OPW-1:0] dt_op;

  assign in_meas = in_tdata[31:0];
  assign in_gyro = in_tdata[63:32];
  assign in_dt   = in_tdata[95:64];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_go    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign s_val = {{2{p00_r[31]}}, p00_r} + {2'b00, r_meas_r};
  assign s_pos = !s_val[33] && (s_val != '0);
  assign dt_op = {1'b0, dt_r};

  kabf_mul u_mul (.clk(clk), .req(mreq), .rs(rs));
  kabf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .quotient(quo));

  always_comb begin
    mreq.en = 1'b1;
    mreq.a  = dt_op;
    mreq.b  = {p11_r[31], p11_r};
    unique case (state_r)
      ST_P2:   mreq.b = {rate_r[31], rate_r};
      ST_P4:   mreq.b = {inner_r[31], inner_r};
      ST_P5:   mreq.b = {1'b0, q_bias_r};
      ST_C1:   begin mreq.a = {k0_r[31], k0_r}; mreq.b = {y_r[31], y_r}; end
      ST_C2:   begin mreq.a = {k1_r[31], k1_r}; mreq.b = {y_r[31], y_r}; end
      ST_C3:   begin mreq.a = {k1_r[31], k1_r}; mreq.b = {p00_r[31], p00_r}; end
      ST_C4:   begin mreq.a = {k1_r[31], k1_r}; mreq.b = {p01_r[31], p01_r}; end
      ST_C5:   begin mreq.a = {k0_r[31], k0_r}; mreq.b = {p00_r[31], p00_r}; end
      ST_C6:   begin mreq.a = {k0_r[31], k0_r}; mreq.b = {p01_r[31], p01_r}; end
      default: mreq.en = (state_r == ST_P1);
    endcase
  end

  always_comb begin
    div_p   = (state_r == ST_D0) ? p00_r : p10_r;
    div_mag = div_p[31] ? 32'(-div_p) : div_p;
    dreq.start    = ((state_r == ST_D0) && s_pos) || ((state_r == ST_D1) && div_done);
    dreq.divisor  = s_val[32:0];
    dreq.dividend = {1'b0, div_mag, 24'd0} + kabf_pkg::DIVW'(s_val[32:1]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (in_dt == '0) ? ST_FIN : ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_P4;
      ST_P4:   state_nxt = ST_P5;
      ST_P5:   state_nxt = ST_P6;
      ST_P6:   state_nxt = ST_D0;
      ST_D0:   state_nxt = s_pos ? ST_D1 : ST_C1;
      ST_D1:   if (div_done) state_nxt = ST_D2;
      ST_D2:   if (div_done) state_nxt = ST_C1;
      ST_C1:   state_nxt = ST_C2;
      ST_C2:   state_nxt = ST_C3;
      ST_C3:   state_nxt = ST_C4;
      ST_C4:   state_nxt = ST_C5;
      ST_C5:   state_nxt = ST_C6;
      ST_C6:   state_nxt = ST_C7;
      ST_C7:   state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_angle_r   <= kabf_pkg::RST_ANGLE_Q;
      q_bias_r    <= kabf_pkg::RST_BIAS_Q;
      r_meas_r    <= kabf_pkg::RST_MEAS_R;
      angle_r     <= '0;
      bias_r      <= '0;
      p00_r       <= '0;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          kabf_pkg::REG_ANGLE_Q: q_angle_r <= cfg_wdata;
          kabf_pkg::REG_BIAS_Q:  q_bias_r  <= cfg_wdata;
          kabf_pkg::REG_MEAS_R:  r_meas_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == ST_FIN) && fin_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_P3: begin
          p01_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p01_r) - kabf_pkg::ext_rs(dtp11_r));
          p10_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p10_r) - kabf_pkg::ext_rs(dtp11_r));
        end
        ST_P5: p00_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p00_r) + kabf_pkg::ext_rs(rs));
        ST_P6: p11_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p11_r) + kabf_pkg::ext_rs(rs));
        ST_C2: angle_r <= kabf_pkg::sat32(kabf_pkg::ext_w(a_r) + kabf_pkg::ext_rs(rs));
        ST_C3: bias_r <= kabf_pkg::sat32(kabf_pkg::ext_w(bias_r) + kabf_pkg::ext_rs(rs));
        ST_C4: p10_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p10_r) - kabf_pkg::ext_rs(rs));
        ST_C5: p11_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p11_r) - kabf_pkg::ext_rs(rs));
        ST_C6: p00_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p00_r) - kabf_pkg::ext_rs(rs));
        ST_C7: p01_r <= kabf_pkg::sat32(kabf_pkg::ext_w(p01_r) - kabf_pkg::ext_rs(rs));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= in_meas;
      dt_r   <= in_dt;
      rate_r <= kabf_pkg::sat32(kabf_pkg::ext_w(in_gyro) - kabf_pkg::ext_w(bias_r));
    end
    unique case (state_r)
      ST_P2: dtp11_r <= rs;
      ST_P3: begin
        a_r     <= kabf_pkg::sat32(kabf_pkg::ext_w(angle_r) + kabf_pkg::ext_rs(rs));
        inner_r <= kabf_pkg::sat32(kabf_pkg::ext_rs(dtp11_r) - kabf_pkg::ext_w(p01_r)
                   - kabf_pkg::ext_w(p10_r) + kabf_pkg::ext_u(q_angle_r));
      end
      ST_P6: y_r <= kabf_pkg::sat32(kabf_pkg::ext_w(meas_r) - kabf_pkg::ext_w(a_r));
      ST_D0: if (!s_pos) begin
        k0_r <= '0;
        k1_r <= '0;
      end
      ST_D1: if (div_done) k0_r <= kabf_pkg::gain_sat(quo, p00_r[31]);
      ST_D2: if (div_done) k1_r <= kabf_pkg::gain_sat(quo, p10_r[31]);
      ST_FIN: if (fin_go) out_data_r <= {rate_r, bias_r, angle_r};
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("input ready outside idle");
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_dt == '0) |=> state_r == ST_FIN)
    else $error("zero time step not skipped");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> (state_r == ST_D0 || state_r == ST_D1))
    else $error("divider started outside gain phase");
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised without finish");
`endif

endmodule

>>> hdl/kabf_mul.sv
// Shared signed multiplier with registered product and round-to-nearest shift by 24.
// Depends on kabf_pkg.
module kabf_mul (
  input  logic               clk,
  input  kabf_pkg::mul_req_t req,
  output kabf_pkg::rs_t      rs
);

  logic signed [kabf_pkg::PRODW-1:0] prod_r;
  logic signed [kabf_pkg::PRODW-1:0] rnd;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= req.a * req.b;
    end
  end

  assign rnd = prod_r + (kabf_pkg::PRODW)'(1 << (kabf_pkg::FRAC_BITS - 1));
  assign rs  = rnd[kabf_pkg::PRODW-1:kabf_pkg::FRAC_BITS];

endmodule

>>> hdl/kabf_div.sv
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// Depends on kabf_pkg.
module kabf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kabf_pkg::div_req_t          req,
  output logic                        done,
  output logic [kabf_pkg::DIVW-1:0]   quotient
);

  localparam int CW = $clog2(kabf_pkg::DIVW + 1);

  logic [kabf_pkg::DSRW-1:0] rem_r;
  logic [kabf_pkg::DSRW-1:0] dsr_r;
  logic [kabf_pkg::DIVW-1:0] quo_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [kabf_pkg::DSRW:0]   trial;
  logic                      ge;

  assign trial = {rem_r, quo_r[kabf_pkg::DIVW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(kabf_pkg::DIVW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dsr_r <= req.divisor;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= ge ? kabf_pkg::DSRW'(trial - {1'b0, dsr_r}) : trial[kabf_pkg::DSRW-1:0];
      quo_r <= {quo_r[kabf_pkg::DIVW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
